/* hdl/swm_pkg.sv */
// package for the sliding window maximum block
// shared widths, reset constants and the cell control struct; no dependencies
package swm_pkg;

  localparam int WINDOW_MAX_DEF   = 64;
  localparam int SAMPLE_WIDTH_DEF = 32;
  localparam int POS_W            = 16;
  localparam int CFG_W            = 7;
  localparam int SEEN_W           = 7;
  localparam logic [CFG_W-1:0]  WSIZE_RESET = CFG_W'(4);
  localparam logic [SEEN_W-1:0] SEEN_MAX    = {SEEN_W{1'b1}};

  typedef struct packed {
    logic shift_only;
    logic step;
    logic drop;
    logic flush;
  } swm_ctrl_t;

endpackage

/* hdl/swm_cell.sv */
// one candidate cell of the monotonic queue chain
// holds value, position and valid; takes from its right neighbor on a shift
// depends on swm_pkg
module swm_cell #(
  parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  swm_pkg::swm_ctrl_t            ctrl,
  input  logic [SAMPLE_WIDTH-1:0]       sample,
  input  logic [swm_pkg::POS_W-1:0]     pos,
  input  logic [swm_pkg::POS_W-1:0]     keff,
  input  logic [SAMPLE_WIDTH-1:0]       r_value,
  input  logic [swm_pkg::POS_W-1:0]     r_position,
  input  logic                          r_valid,
  input  logic                          l_keep,
  output logic [SAMPLE_WIDTH-1:0]       value,
  output logic [swm_pkg::POS_W-1:0]     position,
  output logic                          valid,
  output logic                          stale,
  output logic                          keep,
  output logic [SAMPLE_WIDTH-1:0]       value_next
);
  import swm_pkg::*;

  logic [POS_W-1:0]        age;
  logic [SAMPLE_WIDTH-1:0] v_value;
  logic [POS_W-1:0]        v_position;
  logic                    v_valid;
  logic [POS_W-1:0]        position_next;
  logic                    valid_next;

  assign age   = pos - position;
  assign stale = valid && (age >= keff);

  // view of this slot after the front entry is retired
  assign v_value    = ctrl.drop ? r_value : value;
  assign v_position = ctrl.drop ? r_position : position;
  assign v_valid    = !ctrl.flush && (ctrl.drop ? r_valid : valid);
  assign keep       = v_valid && !($signed(v_value) < $signed(sample));

  always_comb begin
    value_next    = value;
    position_next = position;
    valid_next    = valid;
    if (ctrl.shift_only) begin
      value_next    = r_value;
      position_next = r_position;
      valid_next    = r_valid;
    end else if (ctrl.step) begin
      if (keep) begin
        value_next    = v_value;
        position_next = v_position;
        valid_next    = 1'b1;
      end else if (l_keep) begin
        value_next    = sample;
        position_next = pos;
        valid_next    = 1'b1;
      end else begin
        value_next    = v_value;
        position_next = v_position;
        valid_next    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    value    <= value_next;
    position <= position_next;
  end

endmodule

/* hdl/sliding_window_maximum.sv */
// top level of the sliding window maximum block
// chain of swm_cell candidate cells, window register, counters, output register
// depends on swm_pkg and swm_cell
//
// usage:
//   input channel in_valid/in_ready carries sample and restart; restart clears
//   the window before its sample. config channel cfg_valid/cfg_ready carries
//   window_size (1..WINDOW_MAX, 0 acts as 1, larger acts as WINDOW_MAX) and
//   is always ready; write it only while the block is idle.
//   output channel out_valid/out_ready carries window_max, once the window
//   has filled since the last restart; earlier samples give no transfer.
//   the result is registered and is in the output register in the cycle
//   after the input transfer.
//   throughput: one sample per cycle while the output is free. after the
//   window shrinks, each front candidate beyond the first that has left the
//   window stalls the input for a one-place shift of the whole cell chain.
//   a stalled receiver holds the output register; in_ready also drops while
//   a result waits and out_ready is low.
//   reset: queue empty, counters zero, window_size back to 4.
module sliding_window_maximum #(
  parameter int WINDOW_MAX   = swm_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [SAMPLE_WIDTH-1:0]       sample,
  input  logic                          restart,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [SAMPLE_WIDTH-1:0]       window_max,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [swm_pkg::CFG_W-1:0]     window_size
);
  import swm_pkg::*;

  logic [CFG_W-1:0]        wsize;
  logic [POS_W-1:0]        pos_cnt;
  logic [SEEN_W-1:0]       seen;
  logic [POS_W-1:0]        ws_ext;
  logic [POS_W-1:0]        keff;
  logic [POS_W-1:0]        pos_in;
  logic [SEEN_W-1:0]       seen_base;
  logic [SEEN_W-1:0]       seen_inc;
  logic                    emit;
  logic                    accept;
  logic                    sh;
  logic                    multi;
  swm_ctrl_t               ctrl;

  logic [SAMPLE_WIDTH-1:0] c_value [WINDOW_MAX];
  logic [POS_W-1:0]        c_position [WINDOW_MAX];
  logic [SAMPLE_WIDTH-1:0] c_value_next [WINDOW_MAX];
  logic [WINDOW_MAX-1:0]   c_valid;
  logic [WINDOW_MAX-1:0]   c_keep;
  logic [WINDOW_MAX:0]     stale_pad;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wsize <= WSIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      wsize <= window_size;
    end
  end

  assign ws_ext = POS_W'(wsize);
  assign keff   = (ws_ext == '0) ? POS_W'(1) :
                  (ws_ext > POS_W'(WINDOW_MAX)) ? POS_W'(WINDOW_MAX) : ws_ext;

  assign pos_in    = restart ? '0 : pos_cnt;
  assign seen_base = restart ? '0 : seen;
  assign seen_inc  = (seen_base == SEEN_MAX) ? seen_base : seen_base + SEEN_W'(1);
  assign emit      = POS_W'(seen_inc) >= keff;

  assign stale_pad[WINDOW_MAX] = 1'b0;
  assign sh    = stale_pad[0] && !restart;
  assign multi = sh && stale_pad[1];

  assign in_ready = (!out_valid || out_ready) && !multi;
  assign accept   = in_valid && in_ready;

  always_comb begin
    ctrl.shift_only = in_valid && multi;
    ctrl.step       = accept;
    ctrl.drop       = sh;
    ctrl.flush      = restart;
  end

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    logic [SAMPLE_WIDTH-1:0] r_value;
    logic [POS_W-1:0]        r_position;
    logic                    r_valid;
    logic                    l_keep;

    if (i == WINDOW_MAX - 1) begin : g_last
      assign r_value    = '0;
      assign r_position = '0;
      assign r_valid    = 1'b0;
    end else begin : g_mid
      assign r_value    = c_value[i+1];
      assign r_position = c_position[i+1];
      assign r_valid    = c_valid[i+1];
    end

    if (i == 0) begin : g_first
      assign l_keep = 1'b1;
    end else begin : g_rest
      assign l_keep = c_keep[i-1];
    end

    swm_cell #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .sample    (sample),
      .pos       (pos_in),
      .keff      (keff),
      .r_value   (r_value),
      .r_position(r_position),
      .r_valid   (r_valid),
      .l_keep    (l_keep),
      .value     (c_value[i]),
      .position  (c_position[i]),
      .valid     (c_valid[i]),
      .stale     (stale_pad[i]),
      .keep      (c_keep[i]),
      .value_next(c_value_next[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_cnt   <= '0;
      seen      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        pos_cnt   <= pos_in + POS_W'(1);
        seen      <= seen_inc;
        out_valid <= emit;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      window_max <= c_value_next[0];
    end
  end

  // valid cells always form a prefix from the front
  a_prefix: assert property (@(posedge clk) disable iff (rst)
    (c_valid & (c_valid + WINDOW_MAX'(1))) == '0)
    else $error("candidate valid bits not a prefix");

  // a transfer always leaves the new sample in the queue
  a_front: assert property (@(posedge clk) disable iff (rst)
    accept |=> c_valid[0])
    else $error("queue empty after input transfer");

  // the input only stalls on a free output when the front is stale
  a_stall: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_ready && (!out_valid || out_ready)) |-> (c_valid[0] && c_valid[1 % WINDOW_MAX]))
    else $error("input stalled without stale candidates");

  // a taken result without a new transfer clears the output register
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !accept) |=> !out_valid)
    else $error("result repeated");

endmodule

/* tb/sliding_window_maximum_test.sv */
`timescale 1ns / 1ps
// self-checking testbench for sliding_window_maximum: random handshakes on the input and output channels,
// window maximum predicted per accepted sample and compared with each output transfer
// depends on swm_pkg and sliding_window_maximum
module sliding_window_maximum_test;
  import swm_pkg::*;

  localparam int WIN_DEPTH = WINDOW_MAX_DEF;
  localparam logic [31:0] S_MIN = 32'h8000_0000;
  localparam logic [31:0] S_MAX = 32'h7FFF_FFFF;

  typedef struct {
    logic [31:0] smp;
    logic        rs;
  } sample_item_t;

  logic              clk;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [31:0]       sample = '0;
  logic              restart = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [31:0]       window_max;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_W-1:0]  window_size = WSIZE_RESET;

  sample_item_t sample_q[$];
  logic [31:0]  win_max_q[$];
  int           n_pushed = 0;
  int           n_accepted = 0;
  int           fail_cnt = 0;
  int           gap_left = 0;
  int           stall_left = 0;
  bit           idle_on = 1'b1;

  logic [31:0]      cand_val[WIN_DEPTH];
  logic [POS_W-1:0] cand_pos[WIN_DEPTH];
  int               cand_cnt = 0;
  logic [POS_W-1:0] next_pos = '0;
  int               seen_cnt = 0;
  logic [CFG_W-1:0] win_cfg = WSIZE_RESET;

  sliding_window_maximum u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample     (sample),
    .restart    (restart),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .window_max (window_max),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .window_size(window_size)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic bit track_window_max(input logic [31:0] smp, input logic rs,
                                          output logic [31:0] mx);
    int               k;
    int               drop;
    logic [POS_W-1:0] age;
    if (rs) begin
      cand_cnt = 0;
      seen_cnt = 0;
      next_pos = '0;
    end
    k = int'(win_cfg);
    if (k < 1) k = 1;
    if (k > WIN_DEPTH) k = WIN_DEPTH;
    // retire candidates that have aged out of the window
    drop = 0;
    while (drop < cand_cnt) begin
      age = next_pos - cand_pos[drop];
      if (int'(age) < k) break;
      drop++;
    end
    if (cand_cnt - drop >= WIN_DEPTH) drop = cand_cnt - WIN_DEPTH + 1;
    for (int i = 0; i + drop < cand_cnt; i++) begin
      cand_val[i] = cand_val[i + drop];
      cand_pos[i] = cand_pos[i + drop];
    end
    cand_cnt -= drop;
    // strictly smaller candidates leave from the back, ties stay
    while (cand_cnt > 0 && $signed(cand_val[cand_cnt - 1]) < $signed(smp)) cand_cnt--;
    cand_val[cand_cnt] = smp;
    cand_pos[cand_cnt] = next_pos;
    cand_cnt++;
    next_pos = next_pos + POS_W'(1);
    if (seen_cnt < int'(SEEN_MAX)) seen_cnt++;
    mx = cand_val[0];
    return seen_cnt >= k;
  endfunction

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 70) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [31:0] gen_sample(input int mode, input int idx,
                                             input logic [31:0] base);
    int r;
    r = $urandom_range(0, 99);
    case (mode)
      0: begin
        if (r < 10) begin
          case ($urandom_range(0, 3))
            0: return S_MIN;
            1: return S_MAX;
            2: return '1;
            default: return '0;
          endcase
        end
        if (r < 55) return 32'($urandom_range(0, 16)) - 32'd8;
        return $urandom;
      end
      1: begin
        if (r < 8) return $urandom;
        return base - 32'(idx) * 32'd3 + 32'($urandom_range(0, 2));
      end
      2: begin
        if (r < 8) return $urandom;
        return base + 32'(idx) * 32'd3 - 32'($urandom_range(0, 2));
      end
      default: return 32'($urandom_range(0, 3));
    endcase
  endfunction

  task automatic add_item(input logic [31:0] smp, input logic rs);
    sample_item_t it;
    it.smp = smp;
    it.rs  = rs;
    sample_q = {sample_q, it};
    n_pushed++;
  endtask

  task automatic settle();
    @(posedge clk);
    while (n_accepted != n_pushed || win_max_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_window(input logic [CFG_W-1:0] v);
    @(posedge clk);
    window_size <= v;
    cfg_valid   <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    win_cfg = v;
  endtask

  // input driver
  always @(posedge clk) begin
    sample_item_t nxt;
    logic [31:0]  mx;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready) begin
        if (track_window_max(sample, restart, mx)) win_max_q = {win_max_q, mx};
        n_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (sample_q.size() != 0) begin
          nxt = sample_q[0];
          sample_q.delete(0);
          sample   <= nxt.smp;
          restart  <= nxt.rs;
          in_valid <= 1'b1;
          gap_left <= draw_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output monitor
  always @(posedge clk) begin
    logic [31:0] exp_max;
    int          g;
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (win_max_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("unexpected transfer: window_max=%0d", $signed(window_max));
        end else begin
          exp_max = win_max_q[0];
          win_max_q.delete(0);
          if (window_max !== exp_max) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display("window_max mismatch: expected %0d actual %0d",
                       $signed(exp_max), $signed(window_max));
          end
        end
      end
      if (stall_left != 0) begin
        out_ready  <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        g = draw_gap();
        out_ready  <= (g == 0);
        stall_left <= (g == 0) ? 0 : g - 1;
      end
    end
  end

  initial begin
    logic [CFG_W-1:0] w;
    logic [31:0]      base;
    int               mode;
    int               len;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, ties and restarts at the reset window of 4
    add_item(S_MIN, 1'b1);
    add_item(S_MAX, 1'b0);
    add_item('1, 1'b0);
    add_item('0, 1'b0);
    add_item(32'd1, 1'b0);
    add_item(32'd1, 1'b0);
    add_item(32'd1, 1'b0);
    add_item(-32'sd5, 1'b0);
    add_item(32'd9, 1'b1);
    settle();
    write_window(7'd1);
    add_item(-32'sd3, 1'b0);
    add_item(32'd5, 1'b0);
    add_item(32'd5, 1'b0);
    add_item(32'd100, 1'b1);
    settle();
    // zero acts as one
    write_window(7'd0);
    add_item(32'd7, 1'b1);
    add_item(-32'sd7, 1'b0);
    add_item(S_MIN, 1'b0);
    settle();
    // above the maximum acts as the maximum
    write_window(7'd127);
    add_item(S_MAX, 1'b1);
    add_item(S_MIN, 1'b0);
    add_item(32'd0, 1'b0);
    settle();

    // random phases; window changes without restart retire aged candidates before the next sample
    for (int ph = 0; ph < 16; ph++) begin
      case (ph)
        0: w = 7'd64;
        1: w = 7'd2;
        2: w = 7'd127;
        3: w = 7'd3;
        4: w = 7'd65;
        5: w = 7'd0;
        6: w = 7'd1;
        7: w = 7'd64;
        default: w = ($urandom_range(0, 9) < 7) ? CFG_W'($urandom_range(1, 12))
                                                 : CFG_W'($urandom_range(13, 127));
      endcase
      write_window(w);
      mode = $urandom_range(0, 3);
      base = $urandom;
      for (int i = 0; i < 104; i++) begin
        if (i % 40 == 0) mode = $urandom_range(0, 3);
        add_item(gen_sample(mode, i % 40, base),
                 (i == 0 && $urandom_range(0, 9) < 3) || $urandom_range(0, 99) < 2);
      end
      settle();
    end

    // back-to-back stretch with a restart only on its first sample and no idling
    idle_on = 1'b0;
    write_window(7'd64);
    add_item(gen_sample(0, 0, '0), 1'b1);
    for (int i = 0; i < 200; i += len) begin
      len  = 50;
      mode = $urandom_range(0, 3);
      base = $urandom;
      for (int j = 0; j < len; j++) add_item(gen_sample(mode, j, base), 1'b0);
    end
    settle();
    idle_on = 1'b1;

    // shrink straight after a full window, then grow past the maximum
    write_window(7'd5);
    for (int i = 0; i < 40; i++) add_item(gen_sample(0, i, '0), 1'b0);
    settle();
    write_window(7'd127);
    for (int i = 0; i < 40; i++) add_item(gen_sample(1, i, 32'd5000), 1'b0);
    settle();
    repeat (8) @(posedge clk);

    if (fail_cnt == 0 && win_max_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
